>>> rtl/tdd_pkg.sv
// Package: shared constants and payload types for the tile dedup dictionary.
`timescale 1ns / 1ps

package tdd_pkg;

	localparam int unsigned MAX_ENTRIES = 256;
	localparam int unsigned TABLE_SLOTS = 256;
	localparam int unsigned ADDR_W      = $clog2(TABLE_SLOTS);
	localparam int unsigned CNT_W       = $clog2(TABLE_SLOTS + 1);
	localparam int unsigned KEY_W       = 32;

	localparam logic [CNT_W-1:0] ENTRY_LIMIT =
		CNT_W'((MAX_ENTRIES < TABLE_SLOTS) ? MAX_ENTRIES : TABLE_SLOTS);

	typedef struct packed {
		logic       new_canvas;
		logic [7:0] top_left;
		logic [7:0] top_right;
		logic [7:0] bottom_left;
		logic [7:0] bottom_right;
	} req_t;

	typedef struct packed {
		logic [8:0] tile_id;
		logic       is_new;
		logic       overflow;
	} rsp_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_SCAN = 2'b10
	} state_t;

endpackage

>>> rtl/tile_dedup_dictionary.sv
// Top level: metatile dictionary with a sequential search over a one-read, one-write table.
// The search compares entries up to the current fill (at most 256), with one table
// read and one 32-bit compare per cycle. busy is high until the done cycle, when a
// new start is taken. Reset clears the fill count and the sequencer; table contents
// are left as they are and only entries below the fill count are ever read.
`timescale 1ns / 1ps

module tile_dedup_dictionary (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  tdd_pkg::req_t req,
	output logic          busy,
	output logic          done,
	output tdd_pkg::rsp_t rsp
);

	tdd_pkg::state_t state_q;

	logic [tdd_pkg::KEY_W-1:0]  tbl_mem [tdd_pkg::TABLE_SLOTS];
	logic [tdd_pkg::KEY_W-1:0]  key_q;
	logic [tdd_pkg::CNT_W-1:0]  count_q;
	logic [tdd_pkg::CNT_W-1:0]  rd_idx_q;
	logic [tdd_pkg::KEY_W-1:0]  rd_data_s1;
	logic [tdd_pkg::ADDR_W-1:0] pend_idx_s1;
	logic                       pend_s1;
	logic                       done_q;
	tdd_pkg::rsp_t              rsp_q;

	logic hit;
	logic scan_end;
	logic rd_en;
	logic wr_en;

	assign hit      = pend_s1 && (rd_data_s1 == key_q);
	assign scan_end = (rd_idx_q == count_q);
	assign rd_en    = (state_q == tdd_pkg::S_SCAN) && !hit && !scan_end;
	assign wr_en    = (state_q == tdd_pkg::S_SCAN) && !hit && scan_end
		&& (count_q < tdd_pkg::ENTRY_LIMIT);

	// table: one read and one write port, registered read
	always_ff @(posedge clk) begin
		if (wr_en)
			tbl_mem[count_q[tdd_pkg::ADDR_W-1:0]] <= key_q;
		if (rd_en)
			rd_data_s1 <= tbl_mem[rd_idx_q[tdd_pkg::ADDR_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= tdd_pkg::S_IDLE;
			count_q  <= '0;
			rd_idx_q <= '0;
			pend_s1  <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				tdd_pkg::S_IDLE: begin
					if (start) begin
						if (req.new_canvas)
							count_q <= '0;
						rd_idx_q <= '0;
						pend_s1  <= 1'b0;
						state_q  <= tdd_pkg::S_SCAN;
					end
				end
				tdd_pkg::S_SCAN: begin
					if (hit || scan_end) begin
						pend_s1 <= 1'b0;
						done_q  <= 1'b1;
						state_q <= tdd_pkg::S_IDLE;
						if (wr_en)
							count_q <= count_q + 1'b1;
					end else begin
						pend_s1  <= 1'b1;
						rd_idx_q <= rd_idx_q + 1'b1;
					end
				end
				default: state_q <= tdd_pkg::S_IDLE;
			endcase
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if ((state_q == tdd_pkg::S_IDLE) && start)
			key_q <= {req.top_left, req.top_right, req.bottom_left, req.bottom_right};
		if (rd_en)
			pend_idx_s1 <= rd_idx_q[tdd_pkg::ADDR_W-1:0];
		if ((state_q == tdd_pkg::S_SCAN) && (hit || scan_end)) begin
			if (hit) begin
				rsp_q.tile_id  <= 9'({1'b0, pend_idx_s1} + 9'd1);
				rsp_q.is_new   <= 1'b0;
				rsp_q.overflow <= 1'b0;
			end else if (wr_en) begin
				rsp_q.tile_id  <= 9'(count_q + 1'b1);
				rsp_q.is_new   <= 1'b1;
				rsp_q.overflow <= 1'b0;
			end else begin
				rsp_q.tile_id  <= '0;
				rsp_q.is_new   <= 1'b0;
				rsp_q.overflow <= 1'b1;
			end
		end
	end

	assign busy = (state_q != tdd_pkg::S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	a_new_ovf_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !(rsp_q.is_new && rsp_q.overflow))
		else $error("result beat flags both new and overflow");

	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= tdd_pkg::ENTRY_LIMIT)
		else $error("fill count above limit");

	a_ovf_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && rsp_q.overflow) |-> (rsp_q.tile_id == '0))
		else $error("overflow beat with nonzero id");

	a_new_id_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && rsp_q.is_new) |-> (9'(rsp_q.tile_id) == 9'(count_q)))
		else $error("new entry id does not match fill count");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done_q))
		else $error("accepted beat did not start a search");

endmodule

>>> tb/tile_dict_checker.sv
// Checker: watches the tile dedup dictionary ports, predicts each beat and compares results.
`timescale 1ns / 1ps

module tile_dict_checker
	import tdd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  logic  busy,
	input  req_t  req,
	input  logic  done,
	input  rsp_t  rsp,
	output int    fail_count,
	output int    outstanding
);

	logic [KEY_W-1:0] dict_keys [TABLE_SLOTS];
	int               dict_fill;
	rsp_t             pending_ids [$];
	rsp_t             want;

	initial begin
		fail_count  = 0;
		outstanding = 0;
		dict_fill   = 0;
	end

	task automatic flag_mismatch(input string what);
		$display("ERROR @%0t: %s", $time, what);
		fail_count++;
	endtask

	// Search lowest slot first; append on a miss while there is room.
	function automatic rsp_t dict_lookup(input req_t r);
		logic [KEY_W-1:0] key;
		rsp_t             res;
		int               slot;
		key  = {r.top_left, r.top_right, r.bottom_left, r.bottom_right};
		res  = '0;
		slot = -1;
		if (r.new_canvas)
			dict_fill = 0;
		for (int i = 0; i < dict_fill; i++)
			if (slot < 0 && dict_keys[i] == key)
				slot = i;
		if (slot >= 0) begin
			res.tile_id = 9'(slot + 1);
		end else if (dict_fill < int'(ENTRY_LIMIT)) begin
			dict_keys[dict_fill] = key;
			dict_fill++;
			res.tile_id = 9'(dict_fill);
			res.is_new  = 1'b1;
		end else begin
			res.overflow = 1'b1;
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dict_fill = 0;
			pending_ids.delete();
			outstanding <= 0;
		end else begin
			if ($isunknown(done))
				flag_mismatch("done is unknown");
			// result first: a beat taken on the done edge belongs after it
			if (done === 1'b1) begin
				if (pending_ids.size() == 0) begin
					flag_mismatch("done strobe with no metatile outstanding");
				end else begin
					want = pending_ids.pop_front();
					if (rsp.tile_id !== want.tile_id)
						flag_mismatch($sformatf("tile_id %0d, expected %0d",
							rsp.tile_id, want.tile_id));
					if (rsp.is_new !== want.is_new)
						flag_mismatch($sformatf("is_new %b, expected %b",
							rsp.is_new, want.is_new));
					if (rsp.overflow !== want.overflow)
						flag_mismatch($sformatf("overflow %b, expected %b",
							rsp.overflow, want.overflow));
				end
			end
			if (start === 1'b1 && busy === 1'b0)
				pending_ids.push_back(dict_lookup(req));
			outstanding <= pending_ids.size();
		end
	end

endmodule

>>> tb/tile_dedup_dictionary_tb.sv
// Testbench top: drives metatile beats into the dictionary and reports the verdict.
`timescale 1ns / 1ps

module tile_dedup_dictionary_tb;
	import tdd_pkg::*;

	localparam int N_ITEMS = 1750;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	req_t req    = '0;
	logic busy;
	logic done;
	rsp_t rsp;
	int   fail_count;
	int   outstanding;
	int   sent   = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	tile_dedup_dictionary u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

	tile_dict_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req         (req),
		.done        (done),
		.rsp         (rsp),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	// One beat: optional gap, then hold start until the block takes it.
	task automatic send_tile(input logic nc, input logic [31:0] key);
		bit quiet;
		quiet = (sent >= 600 && sent < 900);
		if (!quiet && $urandom_range(0, 99) < 12) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start <= 1'b1;
		req   <= req_t'({nc, key});
		do @(posedge clk); while (busy);
		sent++;
	endtask

	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	logic [31:0] palette [$];
	logic [31:0] key;
	logic        nc;
	bit          full;
	int          psize;
	int          clen;
	int          canvas_no;

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, hits, byte-position near misses, clears over stale data
		send_tile(1'b0, 32'h0000_0000);
		send_tile(1'b0, 32'h0000_0000);
		send_tile(1'b0, 32'hFFFF_FFFF);
		send_tile(1'b0, 32'hFFFF_FFFF);
		send_tile(1'b0, 32'h0000_0000);
		send_tile(1'b0, 32'h0000_0001);
		send_tile(1'b0, 32'h0000_0100);
		send_tile(1'b0, 32'h0001_0000);
		send_tile(1'b0, 32'h0100_0000);
		send_tile(1'b0, 32'hFFFF_FFFE);
		send_tile(1'b0, 32'h7FFF_FFFF);
		send_tile(1'b0, 32'h0100_0000);
		send_tile(1'b1, 32'hFFFF_FFFF);
		send_tile(1'b0, 32'h0000_0000);
		send_tile(1'b0, 32'h0000_0001);
		send_tile(1'b0, 32'hFFFF_FFFF);
		send_tile(1'b1, 32'h0000_0000);
		send_tile(1'b1, 32'h0000_0000);
		send_tile(1'b0, 32'hA55A_C33C);
		send_tile(1'b0, 32'h5AA5_3CC3);
		send_tile(1'b0, 32'hA55A_C33C);
		drain_results();

		// random canvases: a palette of metatiles, first canvas always fills the table
		canvas_no = 0;
		while (sent < N_ITEMS) begin
			full  = (canvas_no == 0) || ($urandom_range(0, 9) == 0);
			psize = full ? $urandom_range(256, 270) : $urandom_range(1, 48);
			palette.delete();
			for (int i = 0; i < psize; i++)
				palette.push_back($urandom);
			clen = full ? psize + $urandom_range(20, 60) : $urandom_range(psize, 3 * psize);
			for (int j = 0; j < clen && sent < N_ITEMS; j++) begin
				nc = (j == 0);
				if (full && j < psize) begin
					key = palette[j];
				end else begin
					case ($urandom_range(0, 19))
						0:       key = $urandom;
						1:       key = palette[$urandom_range(0, psize - 1)]
							^ (32'h1 << $urandom_range(0, 31));
						default: key = palette[$urandom_range(0, psize - 1)];
					endcase
				end
				// stray clear mid canvas
				if (canvas_no != 0 && !nc && $urandom_range(0, 199) == 0)
					nc = 1'b1;
				send_tile(nc, key);
			end
			if (canvas_no == 3)
				drain_results();
			canvas_no++;
		end

		drain_results();
		repeat (300) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#15_000_000;
		$display("TIMEOUT @%0t", $time);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> filelist.f
rtl/tdd_pkg.sv
rtl/tile_dedup_dictionary.sv
tb/tile_dict_checker.sv
tb/tile_dedup_dictionary_tb.sv
